// ===== rtl/dq_pkg.sv =====
`timescale 1ns / 1ps

package dq_pkg;

   // word and op widths fixed by the stream format
   localparam int WORD_W        = 32;
   localparam int OP_W          = 3;
   localparam int DEPTH_DEFAULT = 1024;

   // operation codes; the unused codes act as a status query
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_STATUS     = 3'd4
   } op_type;

   // per-word outcome flags
   typedef struct packed {
      logic push_dropped;
      logic pop_missed;
   } rsp_flag_type;

endpackage

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words in a ring buffer of DEPTH
// entries. Each request word carries one operation (push front, push back, pop
// front, pop back, status) and gives exactly one response word in the cycle after
// it is taken: the popped word, a missed-pop and a dropped-push flag, the entry
// count and empty flag, and the front and back words (0 when empty). One
// operation is taken every clock cycle while the response register is free or
// being drained; the ring store has one write port and two registered read
// ports that prefetch the end words, so no operation waits on the memory.
// The store needs no clearing after reset.

module double_ended_queue #(
   parameter int  DEPTH    = dq_pkg::DEPTH_DEFAULT,
   localparam int IDX_W    = $clog2(DEPTH),
   localparam int CNT_W    = $clog2(DEPTH + 1),
   localparam int REQ_BITS = dq_pkg::OP_W + dq_pkg::WORD_W,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = 3 * dq_pkg::WORD_W + 3 + CNT_W,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // op, value
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // popped_value, pop_missed, push_dropped, count_now, is_empty,
   // front_value, back_value
   output logic [RSP_W-1:0] rsp_tdata
);
   import dq_pkg::*;

   logic                     accept;
   op_type                   req_op;
   logic signed [WORD_W-1:0] req_value;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [IDX_W-1:0]         front_addr;
   logic [IDX_W-1:0]         back_addr;
   logic signed [WORD_W-1:0] front_word;
   logic signed [WORD_W-1:0] back_word;
   logic signed [WORD_W-1:0] popped;
   rsp_flag_type             flags;
   logic [CNT_W-1:0]         count;
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] popped_ff;
   rsp_flag_type             flags_ff;
   logic                     empty_now;
   logic signed [WORD_W-1:0] front_out;
   logic signed [WORD_W-1:0] back_out;
   logic [RSP_BITS-1:0]      rsp_packed;

   // request word unpacking
   assign req_op    = op_type'(req_tdata[OP_W-1:0]);
   assign req_value = req_tdata[OP_W +: WORD_W];

   // take a new word whenever the response register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   dq_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (req_op),
      .front_word (front_word),
      .back_word  (back_word),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .front_addr (front_addr),
      .back_addr  (back_addr),
      .popped     (popped),
      .flags      (flags),
      .count      (count)
   );

   dq_mem #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_value),
      .rd_en     (accept),
      .rd_addr_a (front_addr),
      .rd_addr_b (back_addr),
      .rd_data_a (front_word),
      .rd_data_b (back_word)
   );

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff <= popped;
         flags_ff  <= flags;
      end
   end

   // end words read as zero on an empty deque
   assign empty_now = (count == '0);
   assign front_out = empty_now ? '0 : front_word;
   assign back_out  = empty_now ? '0 : back_word;

   assign rsp_packed = {back_out, front_out, empty_now, count,
                        flags_ff.push_dropped, flags_ff.pop_missed, popped_ff};
   assign rsp_tdata  = RSP_W'(rsp_packed);
   assign rsp_tvalid = rsp_valid_ff;

   // count never exceeds the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(DEPTH))
      else $error("entry count above ring size");

   // a missed pop is only reported on an empty deque
   a_missed_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && flags_ff.pop_missed |-> empty_now)
      else $error("missed pop with words stored");

   // a dropped push is only reported on a full deque
   a_dropped_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && flags_ff.push_dropped |-> count == CNT_W'(DEPTH))
      else $error("dropped push on a deque with room");

   // queue state holds while a response is stalled
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(count) && $stable(front_out)
                                      && $stable(back_out))
      else $error("queue state moved under a stalled response");

endmodule

// ===== rtl/dq_mem.sv =====
`timescale 1ns / 1ps

module dq_mem #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [IDX_W-1:0]                  wr_addr,
   input  logic signed [dq_pkg::WORD_W-1:0]  wr_data,
   input  logic                              rd_en,
   input  logic [IDX_W-1:0]                  rd_addr_a,
   input  logic [IDX_W-1:0]                  rd_addr_b,
   output logic signed [dq_pkg::WORD_W-1:0]  rd_data_a,
   output logic signed [dq_pkg::WORD_W-1:0]  rd_data_b
);
   import dq_pkg::*;

   logic signed [WORD_W-1:0] store [DEPTH];
   logic signed [WORD_W-1:0] rd_a_ff;
   logic signed [WORD_W-1:0] rd_b_ff;

   // ring store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   // two registered read ports, write data forwarded on an address match
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr_a)) begin
            rd_a_ff <= wr_data;
         end else begin
            rd_a_ff <= store[rd_addr_a];
         end
         if (wr_en && (wr_addr == rd_addr_b)) begin
            rd_b_ff <= wr_data;
         end else begin
            rd_b_ff <= store[rd_addr_b];
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/dq_ctrl.sv =====
`timescale 1ns / 1ps

module dq_ctrl #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  dq_pkg::op_type                    op,
   input  logic signed [dq_pkg::WORD_W-1:0]  front_word,
   input  logic signed [dq_pkg::WORD_W-1:0]  back_word,
   output logic                              wr_en,
   output logic [IDX_W-1:0]                  wr_addr,
   output logic [IDX_W-1:0]                  front_addr,
   output logic [IDX_W-1:0]                  back_addr,
   output logic signed [dq_pkg::WORD_W-1:0]  popped,
   output dq_pkg::rsp_flag_type              flags,
   output logic [CNT_W-1:0]                  count
);
   import dq_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             is_full;
   logic             is_empty;
   logic             push_ok;

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
   endfunction

   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);

   // index and count update for one operation
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      push_ok  = 1'b0;
      popped   = '0;
      flags    = '0;
      case (op)
         OP_PUSH_FRONT: begin
            if (is_full) begin
               flags.push_dropped = 1'b1;
            end else begin
               push_ok  = 1'b1;
               head_in  = idx_prev(head_ff);
               wr_addr  = idx_prev(head_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (is_full) begin
               flags.push_dropped = 1'b1;
            end else begin
               push_ok  = 1'b1;
               wr_addr  = tail_ff;
               tail_in  = idx_next(tail_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               flags.pop_missed = 1'b1;
            end else begin
               popped   = front_word;
               head_in  = idx_next(head_ff);
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (is_empty) begin
               flags.pop_missed = 1'b1;
            end else begin
               popped   = back_word;
               tail_in  = idx_prev(tail_ff);
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      wr_en = accept && push_ok;
   end

   // reads fetch the end words for the state after this operation
   assign front_addr = head_in;
   assign back_addr  = idx_prev(tail_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// ===== bench/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_tb;

   import dq_pkg::*;

   // geometry of the block under test and of its stream words
   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int REQ_W       = ((OP_W + WORD_W + 7) / 8) * 8;
   localparam int RSP_W       = ((3 * WORD_W + 3 + CNT_W + 7) / 8) * 8;
   localparam int OP_CODE_MAX = (1 << OP_W) - 1;

   // response word layout, lowest bit first
   localparam int MISS_BIT  = WORD_W;
   localparam int DROP_BIT  = WORD_W + 1;
   localparam int CNT_LSB   = WORD_W + 2;
   localparam int EMPTY_BIT = CNT_LSB + CNT_W;
   localparam int FRONT_LSB = EMPTY_BIT + 1;
   localparam int BACK_LSB  = FRONT_LSB + WORD_W;

   typedef struct {
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] value;
      logic                     hold;   // wait for every response before sending
      logic                     calm;   // no gaps or stalls around this word
   } deque_request_type;

   typedef struct {
      logic signed [WORD_W-1:0] popped;
      logic                     missed;
      logic                     dropped;
      logic [CNT_W-1:0]         count;
      logic                     empty;
      logic signed [WORD_W-1:0] front;
      logic signed [WORD_W-1:0] back;
   } deque_outcome_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // op, value
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // popped_value, pop_missed, push_dropped, count_now, is_empty,
   // front_value, back_value
   logic [RSP_W-1:0] rsp_tdata;

   deque_request_type request_q[$];
   deque_outcome_type outcome_q[$];
   int unsigned       errors = 0;

   // shadow deque used for prediction
   logic signed [WORD_W-1:0] shadow_ring [DEPTH];
   int                       shadow_head  = 0;
   int                       shadow_tail  = 0;
   int                       shadow_count = 0;

   // generator bookkeeping
   int   gen_count = 0;
   int   gen_items = 0;
   logic gen_calm  = 1'b0;

   // driver and monitor working state
   logic              offer;
   deque_request_type taken;
   int unsigned       gap_left   = 0;
   int unsigned       stall_left = 0;
   logic              calm_now   = 1'b0;

   double_ended_queue #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 10);
      else return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0: return {1'b0, {(WORD_W-1){1'b1}}};
         1: return {1'b1, {(WORD_W-1){1'b0}}};
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic int ring_next(int i);
      return (i + 1 >= DEPTH) ? 0 : i + 1;
   endfunction

   function automatic int ring_prev(int i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   // append one word to the stimulus, tracking the fill level it leads to
   task automatic queue_request(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] value,
                                input logic hold);
      deque_request_type w;
      if (gen_items % 64 == 0)
         gen_calm = ($urandom_range(0, 3) == 0);
      gen_items++;
      w.op    = op;
      w.value = value;
      w.hold  = hold;
      w.calm  = gen_calm;
      request_q.insert(request_q.size(), w);
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
         if (gen_count < DEPTH) gen_count++;
      end else if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
         if (gen_count > 0) gen_count--;
      end
   endtask

   // apply one accepted request to the shadow deque and record its response
   task automatic predict_outcome(input logic [OP_W-1:0] op,
                                  input logic signed [WORD_W-1:0] value);
      deque_outcome_type o;
      o.popped  = '0;
      o.missed  = 1'b0;
      o.dropped = 1'b0;
      case (op)
         OP_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) o.dropped = 1'b1;
            else begin
               shadow_head = ring_prev(shadow_head);
               shadow_ring[shadow_head] = value;
               shadow_count++;
            end
         end
         OP_PUSH_BACK: begin
            if (shadow_count >= DEPTH) o.dropped = 1'b1;
            else begin
               shadow_ring[shadow_tail] = value;
               shadow_tail = ring_next(shadow_tail);
               shadow_count++;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_count == 0) o.missed = 1'b1;
            else begin
               o.popped = shadow_ring[shadow_head];
               shadow_head = ring_next(shadow_head);
               shadow_count--;
            end
         end
         OP_POP_BACK: begin
            if (shadow_count == 0) o.missed = 1'b1;
            else begin
               shadow_tail = ring_prev(shadow_tail);
               o.popped = shadow_ring[shadow_tail];
               shadow_count--;
            end
         end
         default: ;
      endcase
      o.count = shadow_count[CNT_W-1:0];
      o.empty = (shadow_count == 0);
      o.front = '0;
      o.back  = '0;
      if (shadow_count != 0) begin
         o.front = shadow_ring[shadow_head];
         o.back  = shadow_ring[ring_prev(shadow_tail)];
      end
      outcome_q.insert(outcome_q.size(), o);
   endtask

   // compare one response word with the oldest outstanding prediction
   task automatic check_response(input logic [RSP_W-1:0] d);
      deque_outcome_type e;
      logic signed [WORD_W-1:0] got_popped, got_front, got_back;
      logic [CNT_W-1:0] got_count;
      got_popped = d[0 +: WORD_W];
      got_count  = d[CNT_LSB +: CNT_W];
      got_front  = d[FRONT_LSB +: WORD_W];
      got_back   = d[BACK_LSB +: WORD_W];
      if (outcome_q.size() == 0) begin
         $error("response word with no request outstanding: %h", d);
         errors++;
      end else begin
         e = outcome_q[0];
         outcome_q.delete(0);
         if (got_popped !== e.popped) begin
            $error("popped_value expected %0d got %0d", e.popped, got_popped);
            errors++;
         end
         if (d[MISS_BIT] !== e.missed) begin
            $error("pop_missed expected %0d got %0d", e.missed, d[MISS_BIT]);
            errors++;
         end
         if (d[DROP_BIT] !== e.dropped) begin
            $error("push_dropped expected %0d got %0d", e.dropped, d[DROP_BIT]);
            errors++;
         end
         if (got_count !== e.count) begin
            $error("count_now expected %0d got %0d", e.count, got_count);
            errors++;
         end
         if (d[EMPTY_BIT] !== e.empty) begin
            $error("is_empty expected %0d got %0d", e.empty, d[EMPTY_BIT]);
            errors++;
         end
         if (got_front !== e.front) begin
            $error("front_value expected %0d got %0d", e.front, got_front);
            errors++;
         end
         if (got_back !== e.back) begin
            $error("back_value expected %0d got %0d", e.back, got_back);
            errors++;
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         calm_now   <= 1'b0;
         gap_left   = 0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            taken = request_q[0];
            request_q.delete(0);
            predict_outcome(taken.op, taken.value);
            offer    = 1'b0;
            gap_left = taken.calm ? 0 : pick_gap();
         end
         if (!offer) begin
            if (gap_left > 0)
               gap_left--;
            else if (request_q.size() != 0 &&
                     !(request_q[0].hold && outcome_q.size() != 0)) begin
               offer = 1'b1;
               req_tdata <= REQ_W'({request_q[0].value, request_q[0].op});
               calm_now  <= request_q[0].calm;
            end
         end
         req_tvalid <= offer;
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_response(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm_now && $urandom_range(0, 7) == 0) begin
            stall_left = pick_gap();
            rsp_tready <= (stall_left == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int r;
      logic [OP_W-1:0] op;

      // directed: empty edges, extremes, every op, unused codes
      queue_request(OP_STATUS, 32'sd0, 1'b0);
      queue_request(OP_POP_FRONT, 32'sd5, 1'b0);
      queue_request(OP_POP_BACK, -32'sd5, 1'b0);
      queue_request(OP_PUSH_FRONT, {1'b0, {(WORD_W-1){1'b1}}}, 1'b0);
      queue_request(OP_PUSH_BACK, {1'b1, {(WORD_W-1){1'b0}}}, 1'b0);
      queue_request(OP_STATUS, '1, 1'b0);
      queue_request(OP_PUSH_FRONT, '1, 1'b0);
      queue_request(OP_PUSH_BACK, '0, 1'b0);
      queue_request(OP_POP_FRONT, '1, 1'b0);
      queue_request(OP_POP_BACK, '1, 1'b0);
      queue_request(OP_POP_BACK, '0, 1'b0);
      queue_request(OP_POP_FRONT, '0, 1'b0);
      queue_request(OP_POP_FRONT, '0, 1'b0);
      for (int c = int'(OP_STATUS) + 1; c <= OP_CODE_MAX; c++)
         queue_request(c[OP_W-1:0], 32'sh5a5a_a5a5, 1'b0);
      queue_request(OP_PUSH_BACK, 32'sd1, 1'b0);
      queue_request(OP_POP_FRONT, '0, 1'b0);
      queue_request(OP_PUSH_FRONT, 32'sd2, 1'b0);
      queue_request(OP_POP_BACK, '0, 1'b0);

      // random mix near empty, first word waits for the pipe to drain
      for (int i = 0; i < 150; i++)
         queue_request(OP_W'($urandom_range(0, OP_CODE_MAX)), pick_word(), i == 0);

      // fill to the top, then a few pushes that must be dropped
      while (gen_count < DEPTH) begin
         r = $urandom_range(0, 99);
         if (r < 97)
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         else
            op = OP_W'($urandom_range(int'(OP_POP_FRONT), OP_CODE_MAX));
         queue_request(op, pick_word(), 1'b0);
      end
      for (int i = 0; i < 12; i++)
         queue_request($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                       pick_word(), 1'b0);

      // random walk around full
      for (int i = 0; i < 150; i++) begin
         if ($urandom_range(0, 9) != 0)
            op = OP_W'($urandom_range(0, int'(OP_POP_BACK)));
         else
            op = OP_W'($urandom_range(0, OP_CODE_MAX));
         queue_request(op, pick_word(), i == 0);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || req_tvalid || outcome_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
